>>> hdl/mrse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrse_pkg: shared types and constants for the MIPS-I subset executor
// Opcode and function codes, result beat layout, divider request type.
// ----------------------------------------------------------------------------
package mrse_pkg;

	localparam logic [31:0] RESET_PC = 32'hbfc00000;
	localparam logic [31:0] SIGN32   = 32'h80000000;

	// primary opcodes
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_BGTZ    = 6'h07;
	localparam logic [5:0] OP_ADDIMM  = 6'h09;
	localparam logic [5:0] OP_ORI     = 6'h0d;
	localparam logic [5:0] OP_LUI     = 6'h0f;
	localparam logic [5:0] OP_LB      = 6'h20;
	localparam logic [5:0] OP_SW      = 6'h2b;
	localparam logic [3:0] OP_COP_HI  = 4'h4;

	// function codes
	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_SRA  = 6'h03;
	localparam logic [5:0] FN_SLLV = 6'h04;
	localparam logic [5:0] FN_SRLV = 6'h06;
	localparam logic [5:0] FN_SRAV = 6'h07;
	localparam logic [5:0] FN_MFHI = 6'h10;
	localparam logic [5:0] FN_MTHI = 6'h11;
	localparam logic [5:0] FN_MFLO = 6'h12;
	localparam logic [5:0] FN_MTLO = 6'h13;
	localparam logic [5:0] FN_MULT = 6'h18;
	localparam logic [5:0] FN_MULTU = 6'h19;
	localparam logic [5:0] FN_DIV  = 6'h1a;
	localparam logic [5:0] FN_DIVU = 6'h1b;
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_XOR  = 6'h26;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_SLT  = 6'h2a;
	localparam logic [5:0] FN_SLTU = 6'h2b;

	// fault codes
	localparam logic [1:0] FLT_NONE = 2'd0;
	localparam logic [1:0] FLT_ILL  = 2'd1;
	localparam logic [1:0] FLT_COP  = 2'd2;

	// result beat
	typedef struct packed {
		logic [1:0]  fault;
		logic [31:0] store_word;
		logic [31:0] store_addr;
		logic        store_valid;
		logic [31:0] wb_value;
		logic [4:0]  wb_reg;
		logic        wb_valid;
		logic [31:0] next_pc;
	} res_t;

	// divider request
	typedef struct packed {
		logic        start;
		logic        sgn;
		logic [31:0] a;
		logic [31:0] b;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] q;
		logic [31:0] r;
	} div_rsp_t;

endpackage

>>> hdl/mips_r3000_subset_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_r3000_subset_execute: MIPS-I integer subset, one instruction per beat
// Register file and byte data store in synchronous RAMs, iterative divider.
// ----------------------------------------------------------------------------
// channel | dir | fields
// s_axis  | in  | tdata[31:0] instr
// m_axis  | out | tdata: next_pc, wb_valid, wb_reg, wb_value, store_valid,
//         |     |        store_addr, store_word, fault (low bits first)
// Steps: accept with rs/rt read, data store read, execute and write back,
// result offered. sw adds a write for each byte of the word, mult/multu a
// hi/lo load step, div/divu the divider loop and its hand-off.
// Reset clears the register file and the data store in one pass; no beat is
// taken until it is done. DATA_BYTES must be a power of two, which the block
// does not check; data addresses wrap on their low bits.
// Output stall holds the next instruction at s_axis until the result leaves.
// ----------------------------------------------------------------------------
module mips_r3000_subset_execute
	import mrse_pkg::*;
#(
	parameter int DATA_BYTES = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,  // instr
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [143:0] m_axis_tdata   // next_pc, wb_valid, wb_reg, wb_value,
	                                    // store_valid, store_addr, store_word, fault
);

	localparam int AW = $clog2(DATA_BYTES);
	localparam int CLR_N = (DATA_BYTES > 32) ? DATA_BYTES : 32;

	typedef enum logic [7:0] {
		ST_CLR  = 8'b00000001,
		ST_IDLE = 8'b00000010,
		ST_RD   = 8'b00000100,
		ST_EX   = 8'b00001000,
		ST_SW   = 8'b00010000,
		ST_MUL  = 8'b00100000,
		ST_DIV  = 8'b01000000,
		ST_OUT  = 8'b10000000
	} st_t;

	st_t         st_q;
	logic [31:0] gpr_mem [32];
	logic [7:0]  dmem [DATA_BYTES];
	logic [AW:0] clr_q;
	logic [31:0] ins_q, a_q, b_q, hi_q, lo_q, pc_q;
	logic [7:0]  byte_q;
	logic        plv_q;
	logic [4:0]  plr_q;
	logic [31:0] plval_q;
	logic [1:0]  swi_q;
	logic [63:0] prod_q;
	logic        msgn;
	logic signed [32:0] mop_a, mop_b;
	logic signed [65:0] mprod;
	res_t        res_q;
	div_req_t    dreq;
	div_rsp_t    drsp;

	logic [5:0]  op, fn;
	logic [4:0]  rs, rt, rd, sa;
	logic [31:0] simm, seq, eaddr, aa, bb;
	logic [AW-1:0] baddr;

	assign op = ins_q[31:26];
	assign fn = ins_q[5:0];
	assign rs = ins_q[25:21];
	assign rt = ins_q[20:16];
	assign rd = ins_q[15:11];
	assign sa = ins_q[10:6];
	assign simm = {{16{ins_q[15]}}, ins_q[15:0]};
	assign seq = pc_q + 32'd4;
	// pending load is not yet visible: reads see the RAM, which lags
	assign aa = (rs == 5'd0) ? 32'd0 : a_q;
	assign bb = (rt == 5'd0) ? 32'd0 : b_q;
	assign eaddr = aa + simm;
	assign baddr = eaddr[AW-1:0] + ((st_q == ST_SW) ? AW'(swi_q) : AW'(0));

	mrse_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign dreq.start = (st_q == ST_EX) && (op == OP_SPECIAL) && (ins_q != 32'd0)
		&& ((fn == FN_DIV) || (fn == FN_DIVU));
	assign dreq.sgn = (fn == FN_DIV);
	assign dreq.a = aa;
	assign dreq.b = bb;

	assign s_axis_tready = (st_q == ST_IDLE);
	assign m_axis_tvalid = (st_q == ST_OUT);
	assign m_axis_tdata = {7'd0, res_q};

	// register file RAM: read rs/rt, write during clear and retire
	logic        gwe;
	logic [4:0]  gwa;
	logic [31:0] gwd;
	logic        exwv;
	logic [31:0] exval;
	logic [1:0]  exflt;
	logic [31:0] exnpc;
	logic        exlv;

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE) begin
			a_q <= gpr_mem[s_axis_tdata[25:21]];
			b_q <= gpr_mem[s_axis_tdata[20:16]];
		end
		if (gwe) gpr_mem[gwa] <= gwd;
	end

	// byte store RAM
	always_ff @(posedge clk) begin
		byte_q <= dmem[baddr];
		if (st_q == ST_CLR) dmem[clr_q[AW-1:0]] <= 8'd0;
		else if (st_q == ST_SW) dmem[baddr] <= bb[8*swi_q +: 8];
	end

	// signed/unsigned 33x33 multiply, registered before use
	assign msgn = (fn == FN_MULT);
	assign mop_a = {msgn & aa[31], aa};
	assign mop_b = {msgn & bb[31], bb};
	assign mprod = mop_a * mop_b;
	always_ff @(posedge clk) begin
		prod_q <= mprod[63:0];
	end

	// execute decode
	always_comb begin
		exwv = 1'b0; exlv = 1'b0; exval = '0; exflt = FLT_NONE; exnpc = seq;
		if (ins_q == 32'd0) begin
		end else if (op == OP_SPECIAL) begin
			exwv = 1'b1;
			case (fn)
				FN_ADD, FN_ADDU: exval = aa + bb;
				FN_SUB, FN_SUBU: exval = aa - bb;
				FN_AND:  exval = aa & bb;
				FN_OR:   exval = aa | bb;
				FN_XOR:  exval = aa ^ bb;
				FN_NOR:  exval = ~(aa | bb);
				FN_SLT:  exval = {31'd0, $signed(aa) < $signed(bb)};
				FN_SLTU: exval = {31'd0, aa < bb};
				FN_SLL:  exval = bb << sa;
				FN_SRL:  exval = bb >> sa;
				FN_SRA:  exval = 32'($signed(bb) >>> sa);
				FN_SLLV: exval = bb << aa[4:0];
				FN_SRLV: exval = bb >> aa[4:0];
				FN_SRAV: exval = 32'($signed(bb) >>> aa[4:0]);
				FN_MFHI: exval = hi_q;
				FN_MFLO: exval = lo_q;
				FN_MTHI, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: exwv = 1'b0;
				default: begin exwv = 1'b0; exflt = FLT_ILL; end
			endcase
		end else if (op[5:2] == OP_COP_HI) begin
			exflt = FLT_COP;
		end else begin
			case (op)
				OP_J:    exnpc = {seq[31:28], ins_q[25:0], 2'b00};
				OP_BEQ:  if (aa == bb) exnpc = seq + {simm[29:0], 2'b00};
				OP_BNE:  if (aa != bb) exnpc = seq + {simm[29:0], 2'b00};
				OP_BGTZ: if (aa != 32'd0 && !aa[31]) exnpc = seq + {simm[29:0], 2'b00};
				OP_ADDIMM: begin exwv = 1'b1; exval = aa + simm; end
				OP_ORI:   begin exwv = 1'b1; exval = aa | {16'd0, ins_q[15:0]}; end
				OP_LUI:   begin exwv = 1'b1; exval = {ins_q[15:0], 16'd0}; end
				OP_LB:    begin exlv = 1'b1; exval = {{24{byte_q[7]}}, byte_q}; end
				OP_SW: ;
				default: exflt = FLT_ILL;
			endcase
		end
		if (exwv && op == OP_SPECIAL ? rd == 5'd0 : rt == 5'd0) begin
			exwv = 1'b0; exlv = 1'b0; exval = '0;
		end
	end

	logic [4:0] exwr;
	assign exwr = (op == OP_SPECIAL) ? rd : rt;

	// retire: pending load first (ST_EX), then own write (same cycle wins in ST_EX
	// by priority below since own write targets same RAM; own write done in ST_EX
	// only when pending load absent or same reg, else pending in EX, own in OUT)
	logic own_late;
	logic own_late_q;
	assign own_late = plv_q && exwv && (plr_q != exwr) && (plr_q != 5'd0);
	always_comb begin
		gwe = 1'b0; gwa = '0; gwd = '0;
		if (st_q == ST_CLR) begin
			gwe = 1'b1; gwa = clr_q[4:0];
		end else if (st_q == ST_EX) begin
			if (exwv && !own_late) begin
				gwe = 1'b1; gwa = exwr; gwd = exval;
			end else if (plv_q && plr_q != 5'd0) begin
				gwe = 1'b1; gwa = plr_q; gwd = plval_q;
			end
		end else if (st_q == ST_OUT && res_q.wb_valid && !plv_q && own_late_q) begin
			gwe = 1'b1; gwa = res_q.wb_reg; gwd = res_q.wb_value;
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR; clr_q <= '0;
			pc_q <= RESET_PC; hi_q <= '0; lo_q <= '0;
			plv_q <= 1'b0; plr_q <= '0; plval_q <= '0;
			swi_q <= '0; own_late_q <= 1'b0;
			res_q <= '0;
		end else begin
			case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(CLR_N - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: if (s_axis_tvalid) st_q <= ST_RD;
				ST_RD: st_q <= ST_EX;
				ST_EX: begin
					res_q.next_pc <= exnpc;
					res_q.wb_valid <= exwv | exlv;
					res_q.wb_reg <= (exwv | exlv) ? exwr : 5'd0;
					res_q.wb_value <= exval;
					res_q.store_valid <= (ins_q != 0) && (op == OP_SW);
					res_q.store_addr <= (op == OP_SW && ins_q != 0) ? eaddr : 32'd0;
					res_q.store_word <= (op == OP_SW && ins_q != 0) ? bb : 32'd0;
					res_q.fault <= exflt;
					pc_q <= exnpc;
					own_late_q <= own_late;
					plv_q <= exlv; plr_q <= exwr; plval_q <= exval;
					if (own_late) plv_q <= 1'b0;
					if (op == OP_SPECIAL && ins_q != 0 && fn == FN_MTHI) hi_q <= aa;
					if (op == OP_SPECIAL && ins_q != 0 && fn == FN_MTLO) lo_q <= aa;
					swi_q <= '0;
					if (ins_q != 0 && op == OP_SW) st_q <= ST_SW;
					else if (dreq.start) st_q <= ST_DIV;
					else if (op == OP_SPECIAL && ins_q != 0 &&
						(fn == FN_MULT || fn == FN_MULTU)) st_q <= ST_MUL;
					else st_q <= ST_OUT;
				end
				ST_SW: begin
					swi_q <= swi_q + 2'd1;
					if (swi_q == 2'd3) st_q <= ST_OUT;
				end
				ST_MUL: begin
					hi_q <= prod_q[63:32]; lo_q <= prod_q[31:0]; st_q <= ST_OUT;
				end
				ST_DIV: if (drsp.done) begin
					lo_q <= drsp.q; hi_q <= drsp.r; st_q <= ST_OUT;
				end
				ST_OUT: begin
					own_late_q <= 1'b0;
					if (m_axis_tready) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && s_axis_tvalid) ins_q <= s_axis_tdata;
	end

endmodule

>>> hdl/mrse_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrse_div: iterative 32-bit divider
// Restoring radix-2 on magnitudes, one quotient bit per cycle, then sign fix.
// Division by zero and signed overflow follow MIPS results.
// ----------------------------------------------------------------------------
module mrse_div
	import mrse_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q, quo_q, den_q;
	logic        negq_q, negr_q;
	logic [32:0] trial;
	logic [31:0] ma, mb;

	assign ma = (req.sgn && req.a[31]) ? (32'd0 - req.a) : req.a;
	assign mb = (req.sgn && req.b[31]) ? (32'd0 - req.b) : req.b;
	assign trial = {rem_q, quo_q[31]} - {1'b0, den_q};

	// one bit per cycle; zero divisor yields q all ones and r = dividend magnitude,
	// then sign fix gives the MIPS values for both signs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= ma;
			den_q <= mb;
			negq_q <= req.sgn && (req.a[31] ^ req.b[31]);
			negr_q <= req.sgn && req.a[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp = '{done: done_q,
		q: (negq_q ? (32'd0 - quo_q) : quo_q),
		r: (negr_q ? (32'd0 - rem_q) : rem_q)};

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for mips_r3000_subset_execute
// Sends instruction beats and predicts each result beat with a behavioral
// copy of the core: register file, hi/lo, pc, load delay and byte store.
// A directed pass covers some of the instructions and the corner cases. Three
// random passes follow, each with its own mix of sender gaps and receiver
// stalls. Every result beat is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
	import mrse_pkg::*;

	localparam int MEM_BYTES = 4096;
	localparam int WD_LIMIT  = 20000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [31:0]  s_axis_tdata;   // instr
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [143:0] m_axis_tdata;   // next_pc, wb_valid, wb_reg, wb_value,
	                              // store_valid, store_addr, store_word, fault

	mips_r3000_subset_execute #(.DATA_BYTES(MEM_BYTES)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// architectural state of the predicted core
	logic [31:0] arch_gpr [32];
	logic [31:0] arch_hi, arch_lo, arch_pc;
	logic        ld_pend;
	logic [4:0]  ld_reg;
	logic [31:0] ld_val;
	logic [7:0]  arch_mem [MEM_BYTES];

	res_t result_q[$];
	int   errors = 0;
	int   n_sent = 0;
	int   n_done = 0;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   quiet_cycles = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// instruction encoders
	function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
			logic [4:0] rd, logic [4:0] sa);
		return {OP_SPECIAL, rs, rt, rd, sa, fn};
	endfunction

	function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
			logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	// execute one instruction on the predicted state, return its result beat
	function automatic res_t execute_instr(logic [31:0] w);
		res_t r;
		logic [5:0] op, fn;
		logic [4:0] rs, rt, rd, sa, wr;
		logic [31:0] a, b, simm, seq, npc, wval, addr;
		logic signed [31:0] sa_v, sb_v;
		logic signed [63:0] sp;
		logic [63:0] up;
		logic wv, lv, sv;
		logic [1:0] flt;
		op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11];
		sa = w[10:6]; fn = w[5:0];
		simm = {{16{w[15]}}, w[15:0]};
		a = arch_gpr[rs]; b = arch_gpr[rt];
		sa_v = a; sb_v = b;
		seq = arch_pc + 32'd4; npc = seq;
		wv = 0; lv = 0; sv = 0; wr = 0; wval = 0; addr = 0; flt = FLT_NONE;
		if (w == 32'd0) begin
		end else if (op == OP_SPECIAL) begin
			wr = rd; wv = 1;
			case (fn)
				FN_ADD, FN_ADDU: wval = a + b;
				FN_SUB, FN_SUBU: wval = a - b;
				FN_AND:  wval = a & b;
				FN_OR:   wval = a | b;
				FN_XOR:  wval = a ^ b;
				FN_NOR:  wval = ~(a | b);
				FN_SLT:  wval = (sa_v < sb_v) ? 32'd1 : 32'd0;
				FN_SLTU: wval = (a < b) ? 32'd1 : 32'd0;
				FN_SLL:  wval = b << sa;
				FN_SRL:  wval = b >> sa;
				FN_SRA:  wval = sb_v >>> sa;
				FN_SLLV: wval = b << a[4:0];
				FN_SRLV: wval = b >> a[4:0];
				FN_SRAV: wval = sb_v >>> a[4:0];
				FN_MFHI: wval = arch_hi;
				FN_MFLO: wval = arch_lo;
				FN_MTHI: begin wv = 0; arch_hi = a; end
				FN_MTLO: begin wv = 0; arch_lo = a; end
				FN_MULT: begin
					wv = 0; sp = sa_v * sb_v;
					{arch_hi, arch_lo} = sp;
				end
				FN_MULTU: begin
					wv = 0; up = {32'd0, a} * {32'd0, b};
					{arch_hi, arch_lo} = up;
				end
				FN_DIV: begin
					wv = 0;
					if (b == 0) begin
						arch_hi = a; arch_lo = a[31] ? 32'd1 : 32'hffffffff;
					end else if (a == SIGN32 && b == 32'hffffffff) begin
						arch_lo = SIGN32; arch_hi = 0;
					end else begin
						arch_lo = sa_v / sb_v; arch_hi = sa_v % sb_v;
					end
				end
				FN_DIVU: begin
					wv = 0;
					if (b == 0) begin
						arch_hi = a; arch_lo = 32'hffffffff;
					end else begin
						arch_lo = a / b; arch_hi = a % b;
					end
				end
				default: begin wv = 0; flt = FLT_ILL; end
			endcase
		end else if (op[5:2] == OP_COP_HI) begin
			flt = FLT_COP;
		end else begin
			case (op)
				OP_J:     npc = {seq[31:28], w[25:0], 2'b00};
				OP_BEQ:   if (a == b) npc = seq + (simm << 2);
				OP_BNE:   if (a != b) npc = seq + (simm << 2);
				OP_BGTZ:  if (a != 0 && !a[31]) npc = seq + (simm << 2);
				OP_ADDIMM: begin wv = 1; wr = rt; wval = a + simm; end
				OP_ORI:   begin wv = 1; wr = rt; wval = a | {16'd0, w[15:0]}; end
				OP_LUI:   begin wv = 1; wr = rt; wval = {w[15:0], 16'd0}; end
				OP_LB: begin
					lv = 1; wr = rt; addr = a + simm;
					wval = {{24{arch_mem[addr % MEM_BYTES][7]}}, arch_mem[addr % MEM_BYTES]};
					addr = 0;
				end
				OP_SW: begin
					sv = 1; addr = a + simm;
					for (int i = 0; i < 4; i++)
						arch_mem[(addr + i) % MEM_BYTES] = b[8*i +: 8];
				end
				default: flt = FLT_ILL;
			endcase
		end
		if (wr == 0) begin
			wv = 0; lv = 0; wval = 0;
		end
		// retire the delayed load, then this instruction's own write
		if (ld_pend && ld_reg != 0) arch_gpr[ld_reg] = ld_val;
		ld_pend = 0;
		if (wv) arch_gpr[wr] = wval;
		if (lv) begin
			ld_pend = 1; ld_reg = wr; ld_val = wval;
		end
		arch_gpr[0] = 0;
		arch_pc = npc;
		r.next_pc = npc;
		r.wb_valid = wv | lv;
		r.wb_reg = (wv | lv) ? wr : 5'd0;
		r.wb_value = wval;
		r.store_valid = sv;
		r.store_addr = addr;
		r.store_word = sv ? b : 32'd0;
		r.fault = flt;
		return r;
	endfunction

	// send one instruction beat; tvalid only drops when a gap is taken
	task automatic send_instr(input logic [31:0] w);
		if ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= w;
		do @(posedge clk); while (!s_axis_tready);
		result_q.push_back(execute_instr(w));
		n_sent++;
	endtask

	// hold the sender until every predicted result has come back
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (result_q.size() != 0) @(posedge clk);
	endtask

	// register picks lean on a few registers so results feed each other
	function automatic logic [4:0] pick_reg;
		return ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(7));
	endfunction

	function automatic logic [31:0] random_instr;
		logic [5:0] fns [24] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV,
			FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU,
			FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR,
			FN_SLT, FN_SLTU};
		logic [5:0] ops [10] = '{OP_J, OP_BEQ, OP_BNE, OP_BGTZ, OP_ADDIMM, OP_ORI,
			OP_LUI, OP_LB, OP_SW, OP_LB};
		int sel;
		sel = $urandom_range(99);
		if (sel < 8) return $urandom;
		if (sel < 11) return {4'h4, 2'($urandom_range(3)), 26'($urandom)};
		if (sel < 14) return rtype(6'h08 + 6'($urandom_range(4)), pick_reg(), pick_reg(),
			pick_reg(), 5'($urandom));
		if (sel < 55) return rtype(fns[$urandom_range(23)], pick_reg(), pick_reg(),
			pick_reg(), 5'($urandom));
		return itype(ops[$urandom_range(9)], pick_reg(), pick_reg(), 16'($urandom));
	endfunction

	task automatic test_directed;
		send_instr(itype(OP_LUI, 0, 1, 16'h8000));          // r1 = most negative
		send_instr(itype(OP_ADDIMM, 0, 2, 16'hffff));       // r2 = -1
		send_instr(itype(OP_ORI, 0, 3, 16'hffff));
		send_instr(rtype(FN_DIV, 1, 2, 0, 0));              // signed overflow
		send_instr(rtype(FN_MFLO, 0, 0, 4, 0));
		send_instr(rtype(FN_DIV, 3, 0, 0, 0));              // divide by zero
		send_instr(rtype(FN_MFLO, 0, 0, 5, 0));
		send_instr(rtype(FN_DIVU, 1, 0, 0, 0));
		send_instr(rtype(FN_MFHI, 0, 0, 6, 0));
		send_instr(rtype(FN_MULT, 1, 2, 0, 0));
		send_instr(rtype(FN_MFHI, 0, 0, 7, 0));
		send_instr(rtype(FN_SRAV, 2, 1, 8, 0));             // shift amount from rs
		send_instr(rtype(FN_SRA, 0, 1, 9, 31));
		send_instr(itype(OP_SW, 0, 1, 16'hfffe));           // store wraps the top
		send_instr(itype(OP_LB, 0, 10, 16'h0001));          // byte 0x80 at 1
		send_instr(rtype(FN_ADDU, 10, 10, 11, 0));          // sees old r10
		send_instr(itype(OP_LB, 0, 12, 16'h0001));
		send_instr(itype(OP_ADDIMM, 0, 12, 16'h0005));      // own write beats load
		send_instr(rtype(FN_ADDU, 2, 2, 0, 0));             // r0 write dropped
		send_instr(itype(OP_BEQ, 0, 0, 16'h0003));
		send_instr(itype(OP_BNE, 1, 0, 16'hfffe));
		send_instr(itype(OP_BGTZ, 3, 0, 16'h7fff));
		send_instr({OP_J, 26'h3ffffff});
		send_instr({4'h4, 2'd2, 26'h1234567});              // coprocessor
		send_instr(rtype(6'h08, 31, 0, 0, 0));              // jr is not supported
		send_instr(32'd0);
		drain();
	endtask

	task automatic test_random(input int n, input int idle, input int stall);
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < n; i++) begin
			send_instr(random_instr());
			if (i == n / 2) drain();
		end
		drain();
	endtask

	// receiver stalls
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= stall_pct);

	task automatic check_field(input string nm, input logic [31:0] e, input logic [31:0] g);
		if (e !== g) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, nm, e, g);
			errors++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = res_t'(m_axis_tdata[136:0]);
			if (result_q.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, m_axis_tdata);
				errors++;
			end else begin
				want = result_q.pop_front();
				check_field("next_pc", want.next_pc, got.next_pc);
				check_field("wb_valid", want.wb_valid, got.wb_valid);
				check_field("wb_reg", want.wb_reg, got.wb_reg);
				check_field("wb_value", want.wb_value, got.wb_value);
				check_field("store_valid", want.store_valid, got.store_valid);
				check_field("store_addr", want.store_addr, got.store_addr);
				check_field("store_word", want.store_word, got.store_word);
				check_field("fault", want.fault, got.fault);
			end
			n_done++;
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WD_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		for (int i = 0; i < 32; i++) arch_gpr[i] = 0;
		for (int i = 0; i < MEM_BYTES; i++) arch_mem[i] = 0;
		arch_hi = 0; arch_lo = 0; arch_pc = RESET_PC;
		ld_pend = 0; ld_reg = 0; ld_val = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(250, 8, 69);
		test_random(250, 69, 8);
		test_random(250, 0, 0);
		s_axis_tvalid <= 1'b0;
		repeat (50) @(posedge clk);
		if (result_q.size() != 0) begin
			$display("%0d predicted results never arrived", result_q.size());
			errors++;
		end
		$display("Ran %0d instructions (directed corner cases plus three random mixes)",
			n_sent);
		$display("with sender gaps and receiver stalls; %0d results checked, %0d errors",
			n_done, errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> files.f
hdl/mrse_pkg.sv
hdl/mrse_div.sv
hdl/mips_r3000_subset_execute.sv
test/testbench.sv
